>>> src/hisu_pkg.sv
// Package for the homography inlier scoring unit.
// Holds field widths, fixed-point constants and the divider request type.
// No dependencies.
package hisu_pkg;

    localparam int COEF_W  = 32;
    localparam int PT_W    = 16;
    localparam int SQ_W    = 33;
    localparam int TOT_W   = 43;
    localparam int CNT_W   = 11;
    localparam int IDX_W   = 3;

    localparam int ACC_W   = 51;
    localparam int MB_W    = 19;
    localparam int PROD_W  = COEF_W + MB_W;
    localparam int NUM_W   = 57;
    localparam int DEN_W   = 50;
    localparam int QSH     = 18;
    localparam int DSH_W   = DEN_W + QSH;
    localparam int CMP_W   = DSH_W + 2;
    localparam int UQ_W    = QSH + 1;
    localparam int QUO_W   = QSH + 2;
    localparam int DIFF_W  = QUO_W + 1;
    localparam int SUM_W   = 36;

    localparam int DEF_MAX_POINTS       = 1024;
    localparam int DEF_INLIER_THRESHOLD = 30;
    localparam int CNT_ALL_ONES         = 2047;

    localparam logic [IDX_W-1:0] REG_H_XX = 3'd0;
    localparam logic [IDX_W-1:0] REG_H_XY = 3'd1;
    localparam logic [IDX_W-1:0] REG_H_XT = 3'd2;
    localparam logic [IDX_W-1:0] REG_H_YX = 3'd3;
    localparam logic [IDX_W-1:0] REG_H_YY = 3'd4;
    localparam logic [IDX_W-1:0] REG_H_YT = 3'd5;
    localparam logic [IDX_W-1:0] REG_H_PX = 3'd6;
    localparam logic [IDX_W-1:0] REG_H_PY = 3'd7;

    localparam logic [COEF_W-1:0] H_ONE = 32'h4000_0000;

    localparam logic signed [COEF_W-1:0] B_SKEW_HI  = 32'sd107374182;
    localparam logic signed [COEF_W-1:0] B_SKEW_LO  = -32'sd107374182;
    localparam logic signed [COEF_W-1:0] B_SCALE_HI = 32'sd1181116006;
    localparam logic signed [COEF_W-1:0] B_SCALE_LO = 32'sd966367642;

    localparam logic [SQ_W-1:0]  SQ_MAX  = {SQ_W{1'b1}};
    localparam logic [TOT_W-1:0] TOT_MAX = {TOT_W{1'b1}};

    localparam logic signed [ACC_W-1:0] W_ONE = 51'sh4_0000_0000;

    localparam logic signed [DIFF_W-1:0] DIST_HI = 21'sd131072;
    localparam logic signed [DIFF_W-1:0] DIST_LO = -21'sd131072;
    localparam logic [QUO_W-1:0] QBIAS = 20'h4_0000;

    typedef struct packed {
        logic                     start;
        logic signed [NUM_W-1:0]  num;
        logic [DEN_W-1:0]         den;
    } div_req_t;

endpackage

>>> src/hisu_div.sv
// Iterative floor divider for the projected coordinate, one quotient bit per cycle.
// Quotient is clamped to +-2^18 before the bit loop. Uses hisu_pkg.
module hisu_div (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  hisu_pkg::div_req_t                  req,
    output logic                                done,
    output logic signed [hisu_pkg::QUO_W-1:0]   quo
);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_CHK  = 2'd1;
    localparam logic [1:0] PH_ITER = 2'd2;

    logic [1:0]                         phase_reg, phase_next;
    logic signed [hisu_pkg::NUM_W-1:0]  num_reg, num_next;
    logic [hisu_pkg::DSH_W-1:0]         dsh_reg, dsh_next;
    logic [hisu_pkg::DSH_W-1:0]         rem_reg, rem_next;
    logic [hisu_pkg::UQ_W-1:0]          uq_reg, uq_next;
    logic [4:0]                         cnt_reg, cnt_next;
    logic                               done_reg, done_next;
    logic [hisu_pkg::QUO_W-1:0]         quo_reg, quo_next;

    logic signed [hisu_pkg::CMP_W-1:0]  num_ext;
    logic signed [hisu_pkg::CMP_W-1:0]  dsh_ext;
    logic signed [hisu_pkg::CMP_W-1:0]  off_sum;
    logic                               bit_q;
    logic [hisu_pkg::UQ_W-1:0]          uq_shift;

    assign num_ext  = {{(hisu_pkg::CMP_W-hisu_pkg::NUM_W){num_reg[hisu_pkg::NUM_W-1]}}, num_reg};
    assign dsh_ext  = {2'b00, dsh_reg};
    assign off_sum  = num_ext + dsh_ext;
    assign bit_q    = (rem_reg >= dsh_reg);
    assign uq_shift = {uq_reg[hisu_pkg::UQ_W-2:0], bit_q};

    always_comb begin
        phase_next = phase_reg;
        num_next   = num_reg;
        dsh_next   = dsh_reg;
        rem_next   = rem_reg;
        uq_next    = uq_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        quo_next   = quo_reg;
        unique case (phase_reg)
            PH_IDLE: begin
                if (req.start) begin
                    num_next   = req.num;
                    dsh_next   = {req.den, {hisu_pkg::QSH{1'b0}}};
                    phase_next = PH_CHK;
                end
            end
            PH_CHK: begin
                priority if (num_ext >= dsh_ext) begin
                    quo_next   = hisu_pkg::QBIAS;
                    done_next  = 1'b1;
                    phase_next = PH_IDLE;
                end else if (num_ext < -dsh_ext) begin
                    quo_next   = -hisu_pkg::QBIAS;
                    done_next  = 1'b1;
                    phase_next = PH_IDLE;
                end else begin
                    rem_next   = off_sum[hisu_pkg::DSH_W-1:0];
                    uq_next    = '0;
                    cnt_next   = '0;
                    phase_next = PH_ITER;
                end
            end
            PH_ITER: begin
                if (bit_q) begin
                    rem_next = rem_reg - dsh_reg;
                end
                dsh_next = dsh_reg >> 1;
                uq_next  = uq_shift;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'(hisu_pkg::QSH)) begin
                    quo_next   = {1'b0, uq_shift} - hisu_pkg::QBIAS;
                    done_next  = 1'b1;
                    phase_next = PH_IDLE;
                end
            end
            default: begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            done_reg  <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            done_reg  <= done_next;
        end
        num_reg <= num_next;
        dsh_reg <= dsh_next;
        rem_reg <= rem_next;
        uq_reg  <= uq_next;
        cnt_reg <= cnt_next;
        quo_reg <= quo_next;
    end

    assign done = done_reg;
    assign quo  = $signed(quo_reg);

endmodule

>>> src/homography_inlier_scoring_unit.sv
// Homography inlier scoring unit: projects each source point through the
// configured homography and scores it against its target point.
//
// Input channel s_*: one request is a source/target correspondence plus a
// last_point flag; it is taken when s_valid and s_ready are both high.
// Output channel m_*: one result per request with the squared error, inlier
// and degenerate flags, running set totals, the coefficient bounds check and
// set_done. Configuration: cfg_wr_en writes cfg_wdata to register cfg_index
// (0..7 = h_xx, h_xy, h_xt, h_yx, h_yy, h_yt, h_px, h_py) with no wait.
// Timing: one shared 32x19 multiplier forms the six projection products and
// the two squares; one restoring divider produces one quotient bit per cycle
// for x and then y. Each request is carried through to its result before the
// next one can be taken; a point with w <= 0 skips the divider. s_ready is
// high only between requests. The result sits in an output register, so
// s_ready returns while a result still waits; a stalled receiver holds the
// next result in its last step. Reset restores the coefficients to identity,
// clears both set totals and drops any pending result.
module homography_inlier_scoring_unit #(
    parameter int MAX_POINTS       = hisu_pkg::DEF_MAX_POINTS,
    parameter int INLIER_THRESHOLD = hisu_pkg::DEF_INLIER_THRESHOLD
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic signed [hisu_pkg::PT_W-1:0]   s_src_x,
    input  logic signed [hisu_pkg::PT_W-1:0]   s_src_y,
    input  logic signed [hisu_pkg::PT_W-1:0]   s_dst_x,
    input  logic signed [hisu_pkg::PT_W-1:0]   s_dst_y,
    input  logic                               s_last_point,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [hisu_pkg::SQ_W-1:0]          m_sq_err,
    output logic                               m_is_inlier,
    output logic                               m_degenerate,
    output logic [hisu_pkg::TOT_W-1:0]         m_total_err,
    output logic [hisu_pkg::CNT_W-1:0]         m_inlier_count,
    output logic                               m_model_in_bounds,
    output logic                               m_set_done,
    input  logic                               cfg_wr_en,
    input  logic [hisu_pkg::IDX_W-1:0]         cfg_index,
    input  logic [hisu_pkg::COEF_W-1:0]        cfg_wdata
);

    localparam logic [hisu_pkg::CNT_W-1:0] CNT_CAP = hisu_pkg::CNT_W'(
        (MAX_POINTS < hisu_pkg::CNT_ALL_ONES) ? MAX_POINTS : hisu_pkg::CNT_ALL_ONES);
    localparam logic [hisu_pkg::SQ_W-1:0] SQ_THR = hisu_pkg::SQ_W'(INLIER_THRESHOLD * 256);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_CHK  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_WAIT = 3'd4;
    localparam logic [2:0] S_SQ   = 3'd5;
    localparam logic [2:0] S_FIN  = 3'd6;

    logic signed [hisu_pkg::COEF_W-1:0] h_xx_reg, h_xy_reg, h_xt_reg, h_yx_reg;
    logic signed [hisu_pkg::COEF_W-1:0] h_yy_reg, h_yt_reg, h_px_reg, h_py_reg;

    logic [2:0]                          state_reg;
    logic [2:0]                          step_reg;
    logic                                axis_reg;
    logic signed [hisu_pkg::PT_W-1:0]    sx_reg, sy_reg, tx_reg, ty_reg;
    logic                                last_reg;
    logic signed [hisu_pkg::ACC_W-1:0]   x_acc_reg, y_acc_reg, w_acc_reg;
    logic signed [hisu_pkg::PROD_W-1:0]  prod_reg;
    logic signed [hisu_pkg::MB_W-1:0]    dx_reg, dy_reg;
    logic [hisu_pkg::SUM_W-1:0]          sum_reg;
    logic                                degen_reg;

    logic [hisu_pkg::TOT_W-1:0]          err_acc_reg;
    logic [hisu_pkg::CNT_W-1:0]          inl_acc_reg;

    logic                                m_valid_reg;
    logic [hisu_pkg::SQ_W-1:0]           sq_err_reg;
    logic                                is_inlier_reg;
    logic                                degenerate_reg;
    logic [hisu_pkg::TOT_W-1:0]          total_err_reg;
    logic [hisu_pkg::CNT_W-1:0]          inlier_count_reg;
    logic                                in_bounds_reg;
    logic                                set_done_reg;

    logic signed [hisu_pkg::COEF_W-1:0]  mul_a;
    logic signed [hisu_pkg::MB_W-1:0]    mul_b;
    logic signed [hisu_pkg::PROD_W-1:0]  mul_p;
    logic signed [hisu_pkg::ACC_W-1:0]   prod_ext;
    logic [2:0]                          prev_step;

    hisu_pkg::div_req_t                  div_req;
    logic                                div_done;
    logic signed [hisu_pkg::QUO_W-1:0]   div_quo;
    logic signed [hisu_pkg::ACC_W-1:0]   coord;
    logic signed [hisu_pkg::PT_W-1:0]    tgt;
    logic signed [hisu_pkg::DIFF_W-1:0]  diff;
    logic signed [hisu_pkg::MB_W-1:0]    diff_clamp;

    logic [hisu_pkg::SQ_W-1:0]           sq_val;
    logic                                inl_val;
    logic [hisu_pkg::TOT_W:0]            tot_sum;
    logic [hisu_pkg::TOT_W-1:0]          tot_val;
    logic [hisu_pkg::CNT_W-1:0]          cnt_val;
    logic                                bounds_val;
    logic                                out_free;
    logic                                s_fire;
    logic                                fin_fire;

    assign s_ready  = (state_reg == S_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign fin_fire = (state_reg == S_FIN) && out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            h_xx_reg <= hisu_pkg::H_ONE;
            h_xy_reg <= '0;
            h_xt_reg <= '0;
            h_yx_reg <= '0;
            h_yy_reg <= hisu_pkg::H_ONE;
            h_yt_reg <= '0;
            h_px_reg <= '0;
            h_py_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                hisu_pkg::REG_H_XX: h_xx_reg <= cfg_wdata;
                hisu_pkg::REG_H_XY: h_xy_reg <= cfg_wdata;
                hisu_pkg::REG_H_XT: h_xt_reg <= cfg_wdata;
                hisu_pkg::REG_H_YX: h_yx_reg <= cfg_wdata;
                hisu_pkg::REG_H_YY: h_yy_reg <= cfg_wdata;
                hisu_pkg::REG_H_YT: h_yt_reg <= cfg_wdata;
                hisu_pkg::REG_H_PX: h_px_reg <= cfg_wdata;
                hisu_pkg::REG_H_PY: h_py_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // shared multiplier operand select
    always_comb begin
        mul_a = h_xx_reg;
        mul_b = hisu_pkg::MB_W'(sx_reg);
        if (state_reg == S_SQ) begin
            if (step_reg == 3'd0) begin
                mul_a = hisu_pkg::COEF_W'(dx_reg);
                mul_b = dx_reg;
            end else begin
                mul_a = hisu_pkg::COEF_W'(dy_reg);
                mul_b = dy_reg;
            end
        end else begin
            unique case (step_reg)
                3'd0: begin mul_a = h_xx_reg; mul_b = hisu_pkg::MB_W'(sx_reg); end
                3'd1: begin mul_a = h_xy_reg; mul_b = hisu_pkg::MB_W'(sy_reg); end
                3'd2: begin mul_a = h_yx_reg; mul_b = hisu_pkg::MB_W'(sx_reg); end
                3'd3: begin mul_a = h_yy_reg; mul_b = hisu_pkg::MB_W'(sy_reg); end
                3'd4: begin mul_a = h_px_reg; mul_b = hisu_pkg::MB_W'(sx_reg); end
                default: begin mul_a = h_py_reg; mul_b = hisu_pkg::MB_W'(sy_reg); end
            endcase
        end
    end

    assign mul_p     = mul_a * mul_b;
    assign prod_ext  = prod_reg;
    assign prev_step = step_reg - 3'd1;

    assign coord = axis_reg ? y_acc_reg : x_acc_reg;
    assign tgt   = axis_reg ? ty_reg : tx_reg;

    always_comb begin
        div_req.start = (state_reg == S_DIV);
        div_req.num   = {coord[hisu_pkg::ACC_W-1], coord, 5'b00000}
                      + hisu_pkg::NUM_W'(w_acc_reg);
        div_req.den   = {w_acc_reg[hisu_pkg::DEN_W-2:0], 1'b0};
    end

    hisu_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .done    (div_done),
        .quo     (div_quo)
    );

    assign diff = hisu_pkg::DIFF_W'(div_quo) - hisu_pkg::DIFF_W'(tgt);

    always_comb begin
        priority if (diff > hisu_pkg::DIST_HI) begin
            diff_clamp = hisu_pkg::MB_W'(hisu_pkg::DIST_HI);
        end else if (diff < hisu_pkg::DIST_LO) begin
            diff_clamp = hisu_pkg::MB_W'(hisu_pkg::DIST_LO);
        end else begin
            diff_clamp = diff[hisu_pkg::MB_W-1:0];
        end
    end

    always_comb begin
        if (degen_reg) begin
            sq_val = hisu_pkg::SQ_MAX;
        end else if (sum_reg > hisu_pkg::SUM_W'(hisu_pkg::SQ_MAX)) begin
            sq_val = hisu_pkg::SQ_MAX;
        end else begin
            sq_val = sum_reg[hisu_pkg::SQ_W-1:0];
        end
        inl_val = !degen_reg && (sq_val < SQ_THR);
        tot_sum = {1'b0, err_acc_reg} + (hisu_pkg::TOT_W+1)'(sq_val);
        tot_val = tot_sum[hisu_pkg::TOT_W] ? hisu_pkg::TOT_MAX
                                           : tot_sum[hisu_pkg::TOT_W-1:0];
        cnt_val = (inl_val && (inl_acc_reg < CNT_CAP)) ? inl_acc_reg + 1'b1 : inl_acc_reg;
        bounds_val = (h_xx_reg >= hisu_pkg::B_SCALE_LO) && (h_xx_reg <= hisu_pkg::B_SCALE_HI)
                  && (h_yy_reg >= hisu_pkg::B_SCALE_LO) && (h_yy_reg <= hisu_pkg::B_SCALE_HI)
                  && (h_xy_reg >= hisu_pkg::B_SKEW_LO) && (h_xy_reg <= hisu_pkg::B_SKEW_HI)
                  && (h_yx_reg >= hisu_pkg::B_SKEW_LO) && (h_yx_reg <= hisu_pkg::B_SKEW_HI);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            step_reg    <= '0;
            axis_reg    <= 1'b0;
            degen_reg   <= 1'b0;
            err_acc_reg <= '0;
            inl_acc_reg <= '0;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (s_fire) begin
                        step_reg  <= '0;
                        degen_reg <= 1'b0;
                        state_reg <= S_MUL;
                    end
                end
                S_MUL: begin
                    step_reg <= step_reg + 3'd1;
                    if (step_reg == 3'd6) begin
                        state_reg <= S_CHK;
                    end
                end
                S_CHK: begin
                    axis_reg <= 1'b0;
                    if (w_acc_reg <= 0) begin
                        degen_reg <= 1'b1;
                        state_reg <= S_FIN;
                    end else begin
                        state_reg <= S_DIV;
                    end
                end
                S_DIV: begin
                    state_reg <= S_WAIT;
                end
                S_WAIT: begin
                    if (div_done) begin
                        if (!axis_reg) begin
                            axis_reg  <= 1'b1;
                            state_reg <= S_DIV;
                        end else begin
                            step_reg  <= '0;
                            state_reg <= S_SQ;
                        end
                    end
                end
                S_SQ: begin
                    step_reg <= step_reg + 3'd1;
                    if (step_reg == 3'd2) begin
                        state_reg <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        err_acc_reg <= last_reg ? '0 : tot_val;
                        inl_acc_reg <= last_reg ? '0 : cnt_val;
                        state_reg   <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            sx_reg    <= s_src_x;
            sy_reg    <= s_src_y;
            tx_reg    <= s_dst_x;
            ty_reg    <= s_dst_y;
            last_reg  <= s_last_point;
            x_acc_reg <= {h_xt_reg[hisu_pkg::COEF_W-1], h_xt_reg, {hisu_pkg::QSH{1'b0}}};
            y_acc_reg <= {h_yt_reg[hisu_pkg::COEF_W-1], h_yt_reg, {hisu_pkg::QSH{1'b0}}};
            w_acc_reg <= hisu_pkg::W_ONE;
        end
        if (state_reg == S_MUL) begin
            prod_reg <= mul_p;
            if (step_reg != 3'd0) begin
                unique case (prev_step)
                    3'd0, 3'd1: x_acc_reg <= x_acc_reg + prod_ext;
                    3'd2, 3'd3: y_acc_reg <= y_acc_reg + prod_ext;
                    default:    w_acc_reg <= w_acc_reg + prod_ext;
                endcase
            end
        end
        if (state_reg == S_WAIT && div_done) begin
            if (axis_reg) begin
                dy_reg <= diff_clamp;
            end else begin
                dx_reg <= diff_clamp;
            end
        end
        if (state_reg == S_SQ) begin
            prod_reg <= mul_p;
            if (step_reg == 3'd1) begin
                sum_reg <= prod_reg[hisu_pkg::SUM_W-1:0];
            end else if (step_reg == 3'd2) begin
                sum_reg <= sum_reg + prod_reg[hisu_pkg::SUM_W-1:0];
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (fin_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (fin_fire) begin
            sq_err_reg       <= sq_val;
            is_inlier_reg    <= inl_val;
            degenerate_reg   <= degen_reg;
            total_err_reg    <= tot_val;
            inlier_count_reg <= cnt_val;
            in_bounds_reg    <= bounds_val;
            set_done_reg     <= last_reg;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_sq_err          = sq_err_reg;
    assign m_is_inlier       = is_inlier_reg;
    assign m_degenerate      = degenerate_reg;
    assign m_total_err       = total_err_reg;
    assign m_inlier_count    = inlier_count_reg;
    assign m_model_in_bounds = in_bounds_reg;
    assign m_set_done        = set_done_reg;

endmodule

>>> src/hisu_chk.sv
// Port-level checker for the homography inlier scoring unit, with its bind.
// Uses hisu_pkg; attaches to homography_inlier_scoring_unit.
module hisu_chk #(
    parameter int INLIER_THRESHOLD = hisu_pkg::DEF_INLIER_THRESHOLD
) (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_valid,
    input logic                         s_ready,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic [hisu_pkg::SQ_W-1:0]    m_sq_err,
    input logic                         m_is_inlier,
    input logic                         m_degenerate,
    input logic [hisu_pkg::TOT_W-1:0]   m_total_err,
    input logic [hisu_pkg::CNT_W-1:0]   m_inlier_count
);

    localparam logic [hisu_pkg::SQ_W-1:0] SQ_THR = hisu_pkg::SQ_W'(INLIER_THRESHOLD * 256);

    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("block not idle after reset");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request taken while busy");

    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_sq_err) && $stable(m_total_err))
        else $error("stalled result changed");

    a_degenerate: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_degenerate |-> !m_is_inlier && (m_sq_err == hisu_pkg::SQ_MAX))
        else $error("degenerate result not saturated");

    a_inlier: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_is_inlier |-> (m_sq_err < SQ_THR) && (m_inlier_count != '0))
        else $error("inlier flag inconsistent");

endmodule

bind homography_inlier_scoring_unit hisu_chk #(
    .INLIER_THRESHOLD (INLIER_THRESHOLD)
) u_hisu_chk (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_sq_err       (m_sq_err),
    .m_is_inlier    (m_is_inlier),
    .m_degenerate   (m_degenerate),
    .m_total_err    (m_total_err),
    .m_inlier_count (m_inlier_count)
);

>>> bench/tb_homography_inlier_scoring_unit.sv
`timescale 1ns / 1ps
// Testbench for homography_inlier_scoring_unit: sends point correspondences over
// valid/ready and checks each score against a scorer kept inside the bench.
// Depends on hisu_pkg and the unit's RTL.
module tb_homography_inlier_scoring_unit;
    import hisu_pkg::*;

    localparam int     NUM_REGS     = 8;
    localparam int     HOLD_CYCLES  = 400;
    localparam int     STALL_LIMIT  = 4000;
    localparam int     DRAIN_CYCLES = 80;
    localparam int     RANDOM_SETS  = 36;
    localparam longint CNT_CAP      = (DEF_MAX_POINTS < CNT_ALL_ONES) ?
                                      DEF_MAX_POINTS : CNT_ALL_ONES;
    localparam longint INLIER_LIMIT = DEF_INLIER_THRESHOLD * 256;
    localparam longint DIST_CAP     = 131072;

    typedef struct packed {
        logic [SQ_W-1:0]  sq_err;
        logic             is_inlier;
        logic             degenerate;
        logic [TOT_W-1:0] total_err;
        logic [CNT_W-1:0] inlier_count;
        logic             model_in_bounds;
        logic             set_done;
    } score_t;

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     s_valid = 1'b0;
    logic                     s_ready;
    logic signed [PT_W-1:0]   s_src_x = '0;
    logic signed [PT_W-1:0]   s_src_y = '0;
    logic signed [PT_W-1:0]   s_dst_x = '0;
    logic signed [PT_W-1:0]   s_dst_y = '0;
    logic                     s_last_point = 1'b0;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic [SQ_W-1:0]          m_sq_err;
    logic                     m_is_inlier;
    logic                     m_degenerate;
    logic [TOT_W-1:0]         m_total_err;
    logic [CNT_W-1:0]         m_inlier_count;
    logic                     m_model_in_bounds;
    logic                     m_set_done;
    logic                     cfg_wr_en = 1'b0;
    logic [IDX_W-1:0]         cfg_index = '0;
    logic [COEF_W-1:0]        cfg_wdata = '0;

    logic signed [COEF_W-1:0] coef [NUM_REGS];
    logic signed [COEF_W-1:0] next_coef [NUM_REGS];
    longint unsigned          err_sum;
    longint                   inlier_sum;
    score_t                   score_q [$];

    bit steady = 1'b0;
    int hold_left = 0;
    int idle_cycles = 0;
    int mismatches = 0;
    int points_sent = 0;
    int results_seen = 0;
    int sets_closed = 0;
    int settings_used = 0;
    int degenerate_seen = 0;
    int inliers_seen = 0;

    homography_inlier_scoring_unit dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_src_x           (s_src_x),
        .s_src_y           (s_src_y),
        .s_dst_x           (s_dst_x),
        .s_dst_y           (s_dst_y),
        .s_last_point      (s_last_point),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_sq_err          (m_sq_err),
        .m_is_inlier       (m_is_inlier),
        .m_degenerate      (m_degenerate),
        .m_total_err       (m_total_err),
        .m_inlier_count    (m_inlier_count),
        .m_model_in_bounds (m_model_in_bounds),
        .m_set_done        (m_set_done),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic longint floor_div(longint n, longint d);
        longint q;
        q = n / d;
        if (n % d != 0 && n < 0) begin
            q = q - 1;
        end
        return q;
    endfunction

    function automatic longint unsigned dist_sq(longint d);
        if (d > DIST_CAP) begin
            d = DIST_CAP;
        end
        if (d < -DIST_CAP) begin
            d = -DIST_CAP;
        end
        return longint'(d * d);
    endfunction

    function automatic void project(input logic signed [PT_W-1:0] sx, sy,
                                    output longint px, py, output bit degen);
        longint xn, yn, wd;
        xn = longint'(coef[REG_H_XX]) * sx + longint'(coef[REG_H_XY]) * sy +
             longint'(coef[REG_H_XT]) * 262144;
        yn = longint'(coef[REG_H_YX]) * sx + longint'(coef[REG_H_YY]) * sy +
             longint'(coef[REG_H_YT]) * 262144;
        wd = (longint'(1) <<< 34) + longint'(coef[REG_H_PX]) * sx +
             longint'(coef[REG_H_PY]) * sy;
        degen = (wd <= 0);
        px = 0;
        py = 0;
        if (!degen) begin
            px = floor_div(32 * xn + wd, 2 * wd);
            py = floor_div(32 * yn + wd, 2 * wd);
        end
    endfunction

    function automatic bit model_in_bounds();
        return coef[REG_H_XX] >= B_SCALE_LO && coef[REG_H_XX] <= B_SCALE_HI &&
               coef[REG_H_YY] >= B_SCALE_LO && coef[REG_H_YY] <= B_SCALE_HI &&
               coef[REG_H_XY] >= B_SKEW_LO && coef[REG_H_XY] <= B_SKEW_HI &&
               coef[REG_H_YX] >= B_SKEW_LO && coef[REG_H_YX] <= B_SKEW_HI;
    endfunction

    function automatic score_t score_point(input logic signed [PT_W-1:0] sx, sy, tx, ty,
                                           input bit last);
        score_t r;
        longint px, py;
        bit degen, inl;
        longint unsigned sq;
        project(sx, sy, px, py, degen);
        if (degen) begin
            sq = SQ_MAX;
        end else begin
            sq = dist_sq(px - tx) + dist_sq(py - ty);
            if (sq > SQ_MAX) begin
                sq = SQ_MAX;
            end
        end
        inl = !degen && sq < INLIER_LIMIT;
        err_sum = err_sum + sq;
        if (err_sum > TOT_MAX) begin
            err_sum = TOT_MAX;
        end
        if (inl && inlier_sum < CNT_CAP) begin
            inlier_sum++;
        end
        r.sq_err          = sq[SQ_W-1:0];
        r.is_inlier       = inl;
        r.degenerate      = degen;
        r.total_err       = err_sum[TOT_W-1:0];
        r.inlier_count    = inlier_sum[CNT_W-1:0];
        r.model_in_bounds = model_in_bounds();
        r.set_done        = last;
        degenerate_seen  += degen;
        inliers_seen     += inl;
        if (last) begin
            err_sum = 0;
            inlier_sum = 0;
            sets_closed++;
        end
        return r;
    endfunction

    function automatic logic signed [PT_W-1:0] near(longint p, int unsigned spread);
        longint v;
        v = p + longint'($urandom_range(2 * spread)) - spread;
        if (v > 32767) begin
            v = 32767;
        end
        if (v < -32768) begin
            v = -32768;
        end
        return v[PT_W-1:0];
    endfunction

    function automatic logic signed [COEF_W-1:0] jitter(longint base, int unsigned r);
        longint v;
        v = base + longint'($urandom_range(2 * r)) - r;
        return v[COEF_W-1:0];
    endfunction

    function automatic void identity_staging();
        for (int i = 0; i < NUM_REGS; i++) begin
            next_coef[i] = '0;
        end
        next_coef[REG_H_XX] = H_ONE;
        next_coef[REG_H_YY] = H_ONE;
    endfunction

    task automatic check_field(string fname, longint unsigned want, longint unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", fname, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        score_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (score_q.size() == 0) begin
                $error("result with no request outstanding");
                mismatches++;
            end else begin
                want = score_q.pop_front();
                check_field("sq_err", want.sq_err, m_sq_err);
                check_field("is_inlier", want.is_inlier, m_is_inlier);
                check_field("degenerate", want.degenerate, m_degenerate);
                check_field("total_err", want.total_err, m_total_err);
                check_field("inlier_count", want.inlier_count, m_inlier_count);
                check_field("model_in_bounds", want.model_in_bounds, m_model_in_bounds);
                check_field("set_done", want.set_done, m_set_done);
            end
        end
    end

    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left--;
        end else begin
            m_ready <= steady || ($urandom_range(99) >= 18);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    task automatic send_point(input logic signed [PT_W-1:0] sx, sy, tx, ty, input bit last);
        while (!steady && $urandom_range(99) < 18) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_src_x      <= sx;
        s_src_y      <= sy;
        s_dst_x      <= tx;
        s_dst_y      <= ty;
        s_last_point <= last;
        do @(posedge aclk); while (!s_ready);
        score_q.push_back(score_point(sx, sy, tx, ty, last));
        points_sent++;
    endtask

    task automatic send_random(bit last);
        logic signed [PT_W-1:0] sx, sy, tx, ty;
        longint px, py;
        bit degen;
        if ($urandom_range(3) == 0) begin
            sx = $urandom;
            sy = $urandom;
        end else begin
            sx = $urandom_range(4095) - 2048;
            sy = $urandom_range(4095) - 2048;
        end
        project(sx, sy, px, py, degen);
        if (!degen && $urandom_range(99) < 70) begin
            tx = near(px, 90);
            ty = near(py, 90);
        end else begin
            tx = $urandom;
            ty = $urandom;
        end
        send_point(sx, sy, tx, ty, last);
    endtask

    // drop valid and hold until every outstanding result is back
    task automatic wait_idle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (score_q.size() != 0);
    endtask

    task automatic apply_model();
        for (int i = 0; i < NUM_REGS; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= IDX_W'(i);
            cfg_wdata <= next_coef[i];
            coef[i] = next_coef[i];
            @(posedge aclk);
        end
        cfg_wr_en <= 1'b0;
        settings_used++;
    endtask

    task automatic random_model();
        identity_staging();
        case ($urandom_range(3))
            0: begin
                next_coef[REG_H_XX] = jitter(H_ONE, 85899345);
                next_coef[REG_H_YY] = jitter(H_ONE, 85899345);
                next_coef[REG_H_XY] = jitter(0, 85899345);
                next_coef[REG_H_YX] = jitter(0, 85899345);
                next_coef[REG_H_XT] = jitter(0, 13107200);
                next_coef[REG_H_YT] = jitter(0, 13107200);
            end
            1: begin
                next_coef[REG_H_XX] = jitter(H_ONE, 214748364);
                next_coef[REG_H_YY] = jitter(H_ONE, 214748364);
                next_coef[REG_H_XY] = jitter(0, 214748364);
                next_coef[REG_H_YX] = jitter(0, 214748364);
                next_coef[REG_H_XT] = jitter(0, 13107200);
                next_coef[REG_H_YT] = jitter(0, 13107200);
                next_coef[REG_H_PX] = jitter(0, 16384);
                next_coef[REG_H_PY] = jitter(0, 16384);
            end
            2: begin
                for (int i = 0; i < NUM_REGS; i++) begin
                    next_coef[i] = $urandom;
                end
            end
            default: begin
                next_coef[REG_H_XX] = jitter(H_ONE, 53687091);
                next_coef[REG_H_YY] = jitter(H_ONE, 53687091);
                next_coef[REG_H_XT] = jitter(0, 6553600);
                next_coef[REG_H_YT] = jitter(0, 6553600);
                next_coef[REG_H_PX] = jitter(0, 262144);
                next_coef[REG_H_PY] = jitter(0, 262144);
            end
        endcase
        apply_model();
    endtask

    task automatic test_reset_identity();
        send_point(0, 0, 0, 0, 1'b0);
        send_point(-32768, -32768, -32768, -32768, 1'b0);
        send_point(32767, 32767, 32767, 32767, 1'b0);
        send_point(32767, 32767, -32768, -32768, 1'b0);
        send_point(100, 100, 187, 100, 1'b0);
        send_point(100, 100, 188, 100, 1'b0);
        send_point(0, 0, 0, 0, 1'b1);
        wait_idle();
    endtask

    task automatic test_rounding_ties();
        identity_staging();
        next_coef[REG_H_XX] = 32'h2000_0000;
        next_coef[REG_H_YY] = 32'h2000_0000;
        apply_model();
        send_point(1, 1, 1, 1, 1'b0);
        send_point(-1, -1, 0, 0, 1'b1);
        wait_idle();
    endtask

    task automatic test_degenerate();
        identity_staging();
        next_coef[REG_H_PX] = 32'hC000_0000;
        apply_model();
        send_point(16, 0, 0, 0, 1'b0);
        send_point(17, 0, 0, 0, 1'b0);
        send_point(15, 0, 240, 0, 1'b1);
        wait_idle();
    endtask

    task automatic test_distance_clamp();
        identity_staging();
        next_coef[REG_H_XX] = 32'h7FFF_FFFF;
        next_coef[REG_H_XT] = 32'h7FFF_FFFF;
        apply_model();
        send_point(32767, 0, -32768, 0, 1'b0);
        send_point(-32768, 0, 32767, 0, 1'b1);
        wait_idle();
    endtask

    task automatic test_extreme_models();
        for (int i = 0; i < NUM_REGS; i++) begin
            next_coef[i] = 32'h7FFF_FFFF;
        end
        apply_model();
        send_point(32767, 32767, -32768, 32767, 1'b0);
        send_point(-32768, -32768, 32767, -32768, 1'b1);
        wait_idle();
        for (int i = 0; i < NUM_REGS; i++) begin
            next_coef[i] = 32'h8000_0000;
        end
        apply_model();
        send_point(1, 1, -32768, -32768, 1'b0);
        send_point(-32768, -32768, 32767, 32767, 1'b1);
        wait_idle();
    endtask

    task automatic bounds_case(logic signed [COEF_W-1:0] xx, yy, xy, yx);
        identity_staging();
        next_coef[REG_H_XX] = xx;
        next_coef[REG_H_YY] = yy;
        next_coef[REG_H_XY] = xy;
        next_coef[REG_H_YX] = yx;
        apply_model();
        send_point(64, 64, 64, 64, 1'b1);
        wait_idle();
    endtask

    task automatic test_bounds();
        bounds_case(B_SCALE_LO, B_SCALE_HI, B_SKEW_LO, B_SKEW_HI);
        bounds_case(B_SCALE_LO - 1, B_SCALE_HI, B_SKEW_LO, B_SKEW_HI);
        bounds_case(B_SCALE_LO, B_SCALE_HI + 1, B_SKEW_LO, B_SKEW_HI);
        bounds_case(B_SCALE_LO, B_SCALE_HI, B_SKEW_LO - 1, B_SKEW_HI);
        bounds_case(B_SCALE_LO, B_SCALE_HI, B_SKEW_LO, B_SKEW_HI + 1);
    endtask

    task automatic test_backpressure();
        identity_staging();
        apply_model();
        hold_left = HOLD_CYCLES;
        for (int i = 0; i < 8; i++) begin
            send_random(i == 7);
        end
        wait_idle();
    endtask

    // inlier count must pin at its cap while the set keeps going
    task automatic test_count_saturation();
        logic signed [PT_W-1:0] sx, sy;
        longint px, py;
        bit degen;
        int extra;
        random_model_in_bounds();
        extra = 0;
        for (int i = 0; i < 1200 && extra < 4; i++) begin
            steady = (i < 300);
            if (inlier_sum == CNT_CAP) begin
                extra++;
            end
            sx = $urandom_range(32767) - 16384;
            sy = $urandom_range(32767) - 16384;
            project(sx, sy, px, py, degen);
            send_point(sx, sy, near(px, 20), near(py, 20), 1'b0);
        end
        steady = 1'b0;
        send_random(1'b1);
        wait_idle();
    endtask

    task automatic random_model_in_bounds();
        identity_staging();
        next_coef[REG_H_XX] = jitter(H_ONE, 80000000);
        next_coef[REG_H_YY] = jitter(H_ONE, 80000000);
        next_coef[REG_H_XY] = jitter(0, 80000000);
        next_coef[REG_H_YX] = jitter(0, 80000000);
        next_coef[REG_H_XT] = jitter(0, 6553600);
        next_coef[REG_H_YT] = jitter(0, 6553600);
        apply_model();
    endtask

    // error total must pin at full scale; mostly degenerate points
    task automatic test_total_saturation();
        int extra;
        identity_staging();
        next_coef[REG_H_PX] = 32'h8000_0000;
        apply_model();
        extra = 0;
        for (int i = 0; i < 1200 && extra < 3; i++) begin
            if (err_sum == TOT_MAX) begin
                extra++;
            end
            if ($urandom_range(9) == 0) begin
                send_point($urandom, $urandom, $urandom, $urandom, 1'b0);
            end else begin
                send_point($urandom_range(32767, 8), $urandom, $urandom, $urandom, 1'b0);
            end
        end
        send_point($urandom_range(32767, 8), 0, 0, 0, 1'b1);
        wait_idle();
    endtask

    task automatic test_random_sets();
        int len;
        for (int s = 0; s < RANDOM_SETS; s++) begin
            random_model();
            len = $urandom_range(16, 1);
            for (int i = 0; i < len; i++) begin
                send_random(i == len - 1 && $urandom_range(5) != 0);
            end
            wait_idle();
        end
        send_random(1'b1);
        wait_idle();
    endtask

    initial begin
        for (int i = 0; i < NUM_REGS; i++) begin
            coef[i] = '0;
        end
        coef[REG_H_XX] = H_ONE;
        coef[REG_H_YY] = H_ONE;
        err_sum = 0;
        inlier_sum = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        test_reset_identity();
        test_rounding_ties();
        test_degenerate();
        test_distance_clamp();
        test_extreme_models();
        test_bounds();
        test_backpressure();
        test_count_saturation();
        test_total_saturation();
        test_random_sets();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (score_q.size() != 0) begin
            $error("%0d results never arrived", score_q.size());
            mismatches++;
        end
        $display("Scored %0d correspondences in %0d closed sets over %0d coefficient settings,",
                 points_sent, sets_closed, settings_used);
        $display("with %0d degenerate points, %0d inliers and both set totals saturated.",
                 degenerate_seen, inliers_seen);
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

>>> sim.f
src/hisu_pkg.sv
src/hisu_div.sv
src/homography_inlier_scoring_unit.sv
src/hisu_chk.sv
bench/tb_homography_inlier_scoring_unit.sv
